FILE: rtl/plob_pkg.sv
// Shared types and constants of the price-level order book.
package plob_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int MAX_OUT   = 32;
  localparam int PRICE_W   = 32;
  localparam int QTY_W     = 32;
  localparam int REQ_W     = 6;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;
  localparam logic SIDE_BID  = 1'b0;
  localparam logic SIDE_ASK  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESP,
    ST_QUERY
  } state_t;

  typedef struct packed {
    logic               is_ask;
    logic               wr_qty;
    logic               del;
    logic               ins;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } cell_cmd_t;

  typedef struct packed {
    logic better;
    logic equal;
  } cell_stat_t;

endpackage

FILE: rtl/plob_cell.sv
// One price level of a side: holds a price and a quantity and shifts with its neighbors.
module plob_cell (
  input  logic                                clk,
  input  plob_pkg::cell_cmd_t                 cmd,
  input  logic                                occ,
  input  logic                                left_better,
  input  logic [plob_pkg::PRICE_W-1:0]        left_price,
  input  logic [plob_pkg::QTY_W-1:0]          left_qty,
  input  logic [plob_pkg::PRICE_W-1:0]        right_price,
  input  logic [plob_pkg::QTY_W-1:0]          right_qty,
  output plob_pkg::cell_stat_t                stat,
  output logic [plob_pkg::PRICE_W-1:0]        price,
  output logic [plob_pkg::QTY_W-1:0]          qty
);

  logic [plob_pkg::PRICE_W-1:0] price_r, price_nxt;
  logic [plob_pkg::QTY_W-1:0]   qty_r, qty_nxt;
  logic                         better, equal;

  assign better = occ && (cmd.is_ask ? (price_r < cmd.price) : (price_r > cmd.price));
  assign equal  = occ && (price_r == cmd.price);

  always_comb begin
    price_nxt = price_r;
    qty_nxt   = qty_r;
    if (cmd.wr_qty && equal) begin
      qty_nxt = cmd.qty;
    end else if (cmd.del && !better) begin
      price_nxt = right_price;
      qty_nxt   = right_qty;
    end else if (cmd.ins && !better) begin
      if (left_better) begin
        price_nxt = cmd.price;
        qty_nxt   = cmd.qty;
      end else begin
        price_nxt = left_price;
        qty_nxt   = left_qty;
      end
    end
  end

  always_ff @(posedge clk) begin
    price_r <= price_nxt;
    qty_r   <= qty_nxt;
  end

  assign stat.better = better;
  assign stat.equal  = equal;
  assign price       = price_r;
  assign qty         = qty_r;

endmodule

FILE: rtl/plob_side.sv
// One side of the book: a row of level cells kept sorted best first, with its level count.
module plob_side #(
  parameter int DEPTH = plob_pkg::DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1),
  parameter int IW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         is_ask,
  input  logic                         en,
  input  logic [plob_pkg::PRICE_W-1:0] price,
  input  logic [plob_pkg::QTY_W-1:0]   qty,
  input  logic [IW-1:0]                rd_idx,
  output logic [plob_pkg::PRICE_W-1:0] rd_price,
  output logic [plob_pkg::QTY_W-1:0]   rd_qty,
  output logic [CW-1:0]                cnt,
  output logic [plob_pkg::PRICE_W-1:0] best_price,
  output logic                         overflow
);

  logic [CW-1:0]                cnt_r, cnt_nxt;
  plob_pkg::cell_cmd_t          cmd;
  plob_pkg::cell_stat_t         stat_w  [DEPTH];
  logic [plob_pkg::PRICE_W-1:0] price_w [DEPTH];
  logic [plob_pkg::QTY_W-1:0]   qty_w   [DEPTH];
  logic [DEPTH-1:0]             eq_vec, better_vec;
  logic                         found, zero, full, drop;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      assign eq_vec[i]     = stat_w[i].equal;
      assign better_vec[i] = stat_w[i].better;
      plob_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .occ         (CW'(i) < cnt_r),
        .left_better ((i == 0) ? 1'b1 : stat_w[(i == 0) ? 0 : i - 1].better),
        .left_price  (price_w[(i == 0) ? 0 : i - 1]),
        .left_qty    (qty_w[(i == 0) ? 0 : i - 1]),
        .right_price (price_w[(i == DEPTH - 1) ? i : i + 1]),
        .right_qty   (qty_w[(i == DEPTH - 1) ? i : i + 1]),
        .stat        (stat_w[i]),
        .price       (price_w[i]),
        .qty         (qty_w[i])
      );
    end
  endgenerate

  assign found = |eq_vec;
  assign zero  = (qty == '0);
  assign full  = (cnt_r == CW'(DEPTH));
  assign drop  = full && better_vec[DEPTH-1];

  always_comb begin
    cmd.is_ask = is_ask;
    cmd.price  = price;
    cmd.qty    = qty;
    cmd.wr_qty = en && found && !zero;
    cmd.del    = en && found && zero;
    cmd.ins    = en && !found && !zero && !drop;
    cnt_nxt    = cnt_r;
    if (cmd.del) begin
      cnt_nxt = cnt_r - CW'(1);
    end else if (cmd.ins && !full) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign overflow   = en && !found && !zero && full;
  assign cnt        = cnt_r;
  assign best_price = price_w[0];
  assign rd_price   = price_w[rd_idx];
  assign rd_qty     = qty_w[rd_idx];

endmodule

FILE: rtl/price_level_order_book.sv
// Top level of the price-level order book: update and query sequencing and the result register.
//
// The book keeps DEPTH bid levels and DEPTH ask levels, each side a row of cells sorted best
// first. An update word is applied in the cycle it is accepted, all cells of its side compare
// the new price at once and shift, insert, delete or replace in place; its single result word
// is loaded into the output register from the response state. A query word of n levels
// produces n result words, one per cycle while the result side does not stall; a query that
// yields no levels produces no result word. No word is accepted while a result is still
// being produced. The output register holds one result word, so a stall on the result side
// holds the response and query states until the register is free.
module price_level_order_book #(
  parameter int DEPTH = plob_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_op,
  input  logic                         in_side,
  input  logic [plob_pkg::PRICE_W-1:0] in_price,
  input  logic [plob_pkg::QTY_W-1:0]   in_qty,
  input  logic [plob_pkg::REQ_W-1:0]   in_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_bid_valid,
  output logic [plob_pkg::PRICE_W-1:0] out_best_bid_price,
  output logic                         out_ask_valid,
  output logic [plob_pkg::PRICE_W-1:0] out_best_ask_price,
  output logic                         out_overflow,
  output logic [plob_pkg::PRICE_W-1:0] out_level_price,
  output logic [plob_pkg::QTY_W-1:0]   out_level_qty,
  output logic                         out_last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int LW = (CW > plob_pkg::REQ_W) ? CW : plob_pkg::REQ_W;

  plob_pkg::state_t             state_r, state_nxt;
  logic [LW-1:0]                k_r, k_nxt, n_r, n_calc, cnt_x, req_x;
  logic                         qside_r, ovf_r;
  logic                         in_acc, out_free, out_load, q_last;
  logic                         bid_en, ask_en, bid_ovf, ask_ovf;
  logic [CW-1:0]                bid_cnt, ask_cnt;
  logic [plob_pkg::PRICE_W-1:0] bid_best, ask_best, bid_rd_price, ask_rd_price;
  logic [plob_pkg::QTY_W-1:0]   bid_rd_qty, ask_rd_qty;

  logic                         out_valid_r;
  logic                         bid_valid_r, ask_valid_r, overflow_r, last_r;
  logic [plob_pkg::PRICE_W-1:0] best_bid_r, best_ask_r, level_price_r;
  logic [plob_pkg::QTY_W-1:0]   level_qty_r;

  assign in_stall = (state_r != plob_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign bid_en   = in_acc && (in_op == plob_pkg::OP_UPDATE) && (in_side == plob_pkg::SIDE_BID);
  assign ask_en   = in_acc && (in_op == plob_pkg::OP_UPDATE) && (in_side == plob_pkg::SIDE_ASK);

  plob_side #(.DEPTH(DEPTH), .CW(CW), .IW(IW)) u_bid (
    .clk        (clk),
    .rst_n      (rst_n),
    .is_ask     (plob_pkg::SIDE_BID),
    .en         (bid_en),
    .price      (in_price),
    .qty        (in_qty),
    .rd_idx     (k_r[IW-1:0]),
    .rd_price   (bid_rd_price),
    .rd_qty     (bid_rd_qty),
    .cnt        (bid_cnt),
    .best_price (bid_best),
    .overflow   (bid_ovf)
  );

  plob_side #(.DEPTH(DEPTH), .CW(CW), .IW(IW)) u_ask (
    .clk        (clk),
    .rst_n      (rst_n),
    .is_ask     (plob_pkg::SIDE_ASK),
    .en         (ask_en),
    .price      (in_price),
    .qty        (in_qty),
    .rd_idx     (k_r[IW-1:0]),
    .rd_price   (ask_rd_price),
    .rd_qty     (ask_rd_qty),
    .cnt        (ask_cnt),
    .best_price (ask_best),
    .overflow   (ask_ovf)
  );

  always_comb begin
    cnt_x  = (in_side == plob_pkg::SIDE_ASK) ? LW'(ask_cnt) : LW'(bid_cnt);
    req_x  = LW'(in_count);
    n_calc = (cnt_x < req_x) ? cnt_x : req_x;
    if (n_calc > LW'(plob_pkg::MAX_OUT)) begin
      n_calc = LW'(plob_pkg::MAX_OUT);
    end
  end

  assign q_last = ((k_r + LW'(1)) == n_r);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    out_load  = 1'b0;
    case (state_r)
      plob_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_op == plob_pkg::OP_UPDATE) begin
            state_nxt = plob_pkg::ST_RESP;
          end else if (n_calc != '0) begin
            state_nxt = plob_pkg::ST_QUERY;
            k_nxt     = '0;
          end
        end
      end
      plob_pkg::ST_RESP: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = plob_pkg::ST_IDLE;
        end
      end
      plob_pkg::ST_QUERY: begin
        if (out_free) begin
          out_load = 1'b1;
          k_nxt    = k_r + LW'(1);
          if (q_last) begin
            state_nxt = plob_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = plob_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plob_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    if (in_acc) begin
      n_r     <= n_calc;
      qside_r <= in_side;
      ovf_r   <= bid_ovf || ask_ovf;
    end
    if (out_load) begin
      bid_valid_r <= (bid_cnt != '0);
      best_bid_r  <= (bid_cnt != '0) ? bid_best : '0;
      ask_valid_r <= (ask_cnt != '0);
      best_ask_r  <= (ask_cnt != '0) ? ask_best : '0;
      if (state_r == plob_pkg::ST_RESP) begin
        overflow_r    <= ovf_r;
        level_price_r <= '0;
        level_qty_r   <= '0;
        last_r        <= 1'b1;
      end else begin
        overflow_r    <= 1'b0;
        level_price_r <= (qside_r == plob_pkg::SIDE_ASK) ? ask_rd_price : bid_rd_price;
        level_qty_r   <= (qside_r == plob_pkg::SIDE_ASK) ? ask_rd_qty : bid_rd_qty;
        last_r        <= q_last;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bid_valid      = bid_valid_r;
  assign out_best_bid_price = best_bid_r;
  assign out_ask_valid      = ask_valid_r;
  assign out_best_ask_price = best_ask_r;
  assign out_overflow       = overflow_r;
  assign out_level_price    = level_price_r;
  assign out_level_qty      = level_qty_r;
  assign out_last           = last_r;

`ifndef SYNTH
  a_upd_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_op == plob_pkg::OP_UPDATE)) |=> (state_r == plob_pkg::ST_RESP))
    else $error("Accepted update did not move to the response state.");

  a_query_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plob_pkg::ST_QUERY) |-> (k_r < n_r))
    else $error("Query index ran past the level count.");

  a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && overflow_r) |-> (last_r && (level_qty_r == '0)))
    else $error("Overflow flag seen on a query result word.");

  a_empty_bid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !bid_valid_r) |-> (best_bid_r == '0))
    else $error("Empty bid side reported a nonzero best price.");
`endif

endmodule
